// File: rtl/core/tsp_pkg.sv
// Shared types and constants for the transaction stream parser.
// No dependencies; imported by every module of the block.
package tsp_pkg;

   // Widest string length accepted in a length prefix (16..64)
   localparam int LENGTH_BITS = 64;
   localparam logic [63:0] LEN_MASK =
      (LENGTH_BITS >= 64) ? {64{1'b1}} : ((64'd1 << LENGTH_BITS) - 64'd1);

   // Trailer marker, first byte in the low lane
   localparam logic [63:0] MARKER_WORD = 64'h3142_432D_4252_414C;
   localparam logic [63:0] MARKER_LEN  = 64'd8;

   typedef enum logic [17:0] {
      PH_VERSION     = 18'd1,
      PH_IN_COUNT    = 18'd2,
      PH_ID_LEN      = 18'd4,
      PH_ID_DATA     = 18'd8,
      PH_OUT_INDEX   = 18'd16,
      PH_KEY_LEN     = 18'd32,
      PH_KEY_DATA    = 18'd64,
      PH_SIG_LEN     = 18'd128,
      PH_SIG_DATA    = 18'd256,
      PH_OUT_COUNT   = 18'd512,
      PH_AMOUNT      = 18'd1024,
      PH_SCRIPT_LEN  = 18'd2048,
      PH_SCRIPT_DATA = 18'd4096,
      PH_MARK_LEN    = 18'd8192,
      PH_MARK_DATA   = 18'd16384,
      PH_CB_LEN      = 18'd32768,
      PH_CB_DATA     = 18'd65536,
      PH_DONE        = 18'd131072
   } phase_type;

   typedef enum logic [4:0] {
      KIND_VERSION     = 5'd0,
      KIND_IN_COUNT    = 5'd1,
      KIND_ID_LEN      = 5'd2,
      KIND_ID_DATA     = 5'd3,
      KIND_OUT_INDEX   = 5'd4,
      KIND_KEY_LEN     = 5'd5,
      KIND_KEY_DATA    = 5'd6,
      KIND_SIG_LEN     = 5'd7,
      KIND_SIG_DATA    = 5'd8,
      KIND_OUT_COUNT   = 5'd9,
      KIND_AMOUNT      = 5'd10,
      KIND_SCRIPT_LEN  = 5'd11,
      KIND_SCRIPT_DATA = 5'd12,
      KIND_MARK_LEN    = 5'd13,
      KIND_MARK_DATA   = 5'd14,
      KIND_CB_LEN      = 5'd15,
      KIND_CB_DATA     = 5'd16,
      KIND_TRAILING    = 5'd17,
      KIND_DISCARD     = 5'd18
   } field_kind_type;

   typedef enum logic [2:0] {
      ST_BUSY       = 3'd0,
      ST_ACCEPTED   = 3'd1,
      ST_TRUNCATED  = 3'd2,
      ST_STR_TRUNC  = 3'd3,
      ST_BAD_MARKER = 3'd4,
      ST_EMPTY_CB   = 3'd5,
      ST_EXTRA      = 3'd6,
      ST_DISCARDING = 3'd7
   } status_type;

   typedef struct packed {
      field_kind_type field_kind;
      logic [63:0]    entry_index;
      logic [63:0]    field_value;
      logic           value_valid;
      status_type     status;
      logic           tx_done;
   } result_type;

   function automatic field_kind_type phase_kind(input phase_type ph);
      field_kind_type k;
      unique case (ph)
         PH_VERSION:     k = KIND_VERSION;
         PH_IN_COUNT:    k = KIND_IN_COUNT;
         PH_ID_LEN:      k = KIND_ID_LEN;
         PH_ID_DATA:     k = KIND_ID_DATA;
         PH_OUT_INDEX:   k = KIND_OUT_INDEX;
         PH_KEY_LEN:     k = KIND_KEY_LEN;
         PH_KEY_DATA:    k = KIND_KEY_DATA;
         PH_SIG_LEN:     k = KIND_SIG_LEN;
         PH_SIG_DATA:    k = KIND_SIG_DATA;
         PH_OUT_COUNT:   k = KIND_OUT_COUNT;
         PH_AMOUNT:      k = KIND_AMOUNT;
         PH_SCRIPT_LEN:  k = KIND_SCRIPT_LEN;
         PH_SCRIPT_DATA: k = KIND_SCRIPT_DATA;
         PH_MARK_LEN:    k = KIND_MARK_LEN;
         PH_MARK_DATA:   k = KIND_MARK_DATA;
         PH_CB_LEN:      k = KIND_CB_LEN;
         PH_CB_DATA:     k = KIND_CB_DATA;
         default:        k = KIND_TRAILING;
      endcase
      return k;
   endfunction

endpackage

// File: rtl/core/tsp_parse.sv
// Parser state registers and the per-byte update logic.
// Depends on tsp_pkg; the state advances only when step is high.
module tsp_parse
   import tsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       end_of_tx,
   output result_type result
);

   phase_type              phase_ff, phase_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic [63:0]            accum_ff, accum_in;
   logic [LENGTH_BITS-1:0] str_rem_ff, str_rem_in;
   logic [63:0]            ent_rem_ff, ent_rem_in;
   logic [63:0]            ent_ctr_ff, ent_ctr_in;
   logic                   mismatch_ff, mismatch_in;
   logic                   err_ff, err_in;

   logic [63:0]            acc_new;
   logic [LENGTH_BITS-1:0] rem_after;
   logic [2:0]             mark_pos;
   logic                   fixed_done;
   logic                   end_str;
   phase_type              str_phase;
   status_type             err_code;
   phase_type              start_phase;
   logic                   start_str;

   always_comb begin
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      accum_in    = accum_ff;
      str_rem_in  = str_rem_ff;
      ent_rem_in  = ent_rem_ff;
      ent_ctr_in  = ent_ctr_ff;
      mismatch_in = mismatch_ff;
      err_in      = err_ff;

      result.field_kind  = KIND_DISCARD;
      result.entry_index = '0;
      result.field_value = '0;
      result.value_valid = 1'b0;
      result.status      = ST_BUSY;
      result.tx_done     = 1'b0;

      acc_new = accum_ff;
      acc_new[{cnt_ff, 3'b000} +: 8] = data_byte;
      fixed_done = (phase_ff == PH_VERSION || phase_ff == PH_OUT_INDEX) ?
                   (cnt_ff == 3'd3) : (cnt_ff == 3'd7);
      rem_after  = (str_rem_ff == '0) ? '0 : str_rem_ff - 1'b1;
      mark_pos   = 3'(3'd0 - str_rem_ff[2:0]);

      end_str     = 1'b0;
      str_phase   = phase_ff;
      start_str   = 1'b0;
      start_phase = phase_ff;
      err_code    = ST_BUSY;

      if (err_ff) begin
         result.status = ST_DISCARDING;
      end else begin
         result.field_kind = phase_kind(phase_ff);
         if (phase_ff == PH_ID_LEN || phase_ff == PH_ID_DATA ||
             phase_ff == PH_OUT_INDEX || phase_ff == PH_KEY_LEN ||
             phase_ff == PH_KEY_DATA || phase_ff == PH_SIG_LEN ||
             phase_ff == PH_SIG_DATA || phase_ff == PH_AMOUNT ||
             phase_ff == PH_SCRIPT_LEN || phase_ff == PH_SCRIPT_DATA)
            result.entry_index = ent_ctr_ff;

         unique case (phase_ff)
            PH_VERSION, PH_IN_COUNT, PH_ID_LEN, PH_OUT_INDEX, PH_KEY_LEN,
            PH_SIG_LEN, PH_OUT_COUNT, PH_AMOUNT, PH_SCRIPT_LEN, PH_MARK_LEN,
            PH_CB_LEN: begin
               if (fixed_done) begin
                  result.field_value = acc_new;
                  result.value_valid = 1'b1;
                  cnt_in   = '0;
                  accum_in = '0;
                  unique case (phase_ff)
                     PH_VERSION:    phase_in = PH_IN_COUNT;
                     PH_OUT_INDEX:  phase_in = PH_KEY_LEN;
                     PH_AMOUNT:     phase_in = PH_SCRIPT_LEN;
                     PH_IN_COUNT: begin
                        ent_rem_in = acc_new;
                        ent_ctr_in = '0;
                        phase_in   = (acc_new == '0) ? PH_OUT_COUNT : PH_ID_LEN;
                     end
                     PH_OUT_COUNT: begin
                        ent_rem_in = acc_new;
                        ent_ctr_in = '0;
                        phase_in   = (acc_new == '0) ? PH_MARK_LEN : PH_AMOUNT;
                     end
                     PH_ID_LEN: begin
                        start_str   = 1'b1;
                        start_phase = PH_ID_DATA;
                     end
                     PH_KEY_LEN: begin
                        start_str   = 1'b1;
                        start_phase = PH_KEY_DATA;
                     end
                     PH_SIG_LEN: begin
                        start_str   = 1'b1;
                        start_phase = PH_SIG_DATA;
                     end
                     PH_SCRIPT_LEN: begin
                        start_str   = 1'b1;
                        start_phase = PH_SCRIPT_DATA;
                     end
                     PH_MARK_LEN: begin
                        mismatch_in = (acc_new != MARKER_LEN);
                        start_str   = 1'b1;
                        start_phase = PH_MARK_DATA;
                     end
                     default: begin
                        if (acc_new == '0) begin
                           err_code = ST_EMPTY_CB;
                        end else begin
                           start_str   = 1'b1;
                           start_phase = PH_CB_DATA;
                        end
                     end
                  endcase
               end else begin
                  cnt_in   = cnt_ff + 3'd1;
                  accum_in = acc_new;
               end
            end
            PH_ID_DATA, PH_KEY_DATA, PH_SIG_DATA, PH_SCRIPT_DATA, PH_MARK_DATA,
            PH_CB_DATA: begin
               if (phase_ff == PH_MARK_DATA && !mismatch_ff &&
                   data_byte != MARKER_WORD[{mark_pos, 3'b000} +: 8])
                  mismatch_in = 1'b1;
               str_rem_in = rem_after;
               end_str    = (rem_after == '0);
               str_phase  = phase_ff;
            end
            default: begin
               result.field_kind = KIND_TRAILING;
               err_code = ST_EXTRA;
            end
         endcase

         if (start_str) begin
            if ((acc_new & ~LEN_MASK) != '0) begin
               err_code = ST_STR_TRUNC;
            end else begin
               str_rem_in = acc_new[LENGTH_BITS-1:0];
               if (acc_new == '0) begin
                  end_str   = 1'b1;
                  str_phase = start_phase;
               end else begin
                  phase_in = start_phase;
               end
            end
         end

         if (end_str) begin
            unique case (str_phase)
               PH_ID_DATA:  phase_in = PH_OUT_INDEX;
               PH_KEY_DATA: phase_in = PH_SIG_LEN;
               PH_SIG_DATA, PH_SCRIPT_DATA: begin
                  ent_ctr_in = ent_ctr_ff + 64'd1;
                  ent_rem_in = ent_rem_ff - 64'd1;
                  if (str_phase == PH_SIG_DATA)
                     phase_in = (ent_rem_ff == 64'd1) ? PH_OUT_COUNT : PH_ID_LEN;
                  else
                     phase_in = (ent_rem_ff == 64'd1) ? PH_MARK_LEN : PH_AMOUNT;
               end
               PH_MARK_DATA: begin
                  if (mismatch_in)
                     err_code = ST_BAD_MARKER;
                  else
                     phase_in = PH_CB_LEN;
               end
               default: phase_in = PH_DONE;
            endcase
         end

         if (err_code != ST_BUSY) begin
            result.status  = err_code;
            result.tx_done = 1'b1;
            err_in         = 1'b1;
         end else if (end_of_tx) begin
            result.tx_done = 1'b1;
            if ((phase_in == PH_MARK_LEN && cnt_in == '0) || phase_in == PH_DONE)
               result.status = ST_ACCEPTED;
            else if (phase_in == PH_ID_DATA || phase_in == PH_KEY_DATA ||
                     phase_in == PH_SIG_DATA || phase_in == PH_SCRIPT_DATA ||
                     phase_in == PH_MARK_DATA || phase_in == PH_CB_DATA)
               result.status = ST_STR_TRUNC;
            else
               result.status = ST_TRUNCATED;
         end
      end

      // last byte of a transaction: back to the start for the next one
      if (end_of_tx) begin
         result.tx_done = 1'b1;
         phase_in    = PH_VERSION;
         cnt_in      = '0;
         accum_in    = '0;
         str_rem_in  = '0;
         ent_rem_in  = '0;
         ent_ctr_in  = '0;
         mismatch_in = 1'b0;
         err_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_VERSION;
         cnt_ff      <= '0;
         accum_ff    <= '0;
         str_rem_ff  <= '0;
         ent_rem_ff  <= '0;
         ent_ctr_ff  <= '0;
         mismatch_ff <= 1'b0;
         err_ff      <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
         accum_ff    <= accum_in;
         str_rem_ff  <= str_rem_in;
         ent_rem_ff  <= ent_rem_in;
         ent_ctr_ff  <= ent_ctr_in;
         mismatch_ff <= mismatch_in;
         err_ff      <= err_in;
      end
   end

endmodule

// File: rtl/core/transaction_stream_parser.sv
// Top level of the transaction stream parser: request register, parser, result register.
// Depends on tsp_pkg and tsp_parse.
//
//   channel | direction | handshake        | payload
//   req     | in        | req_valid/ready  | data_byte, end_of_tx
//   rsp     | out       | rsp_valid/ready  | field_kind, entry_index, field_value,
//           |           |                  | value_valid, status, tx_done
//
// One request a cycle sustained while rsp_ready is high; each result goes from its
// request through the request register, then parser logic into the result register.
// Synchronous reset clears the parser state and both valid flags.
// A stalled result holds in its register; the request register takes one more request
// only if it is empty and passes it on as soon as the result slot frees.
module transaction_stream_parser
   import tsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_tx,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_field_kind,
   output logic [63:0] rsp_entry_index,
   output logic [63:0] rsp_field_value,
   output logic        rsp_value_valid,
   output logic [2:0]  rsp_status,
   output logic        rsp_tx_done
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type step_result;
   logic       move;

   assign move      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || move;

   tsp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (move),
      .data_byte (in_byte_ff),
      .end_of_tx (in_end_ff),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= (req_valid && req_ready) || (in_valid_ff && !move);
         rsp_valid_ff <= move || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_end_ff  <= req_end_of_tx;
      end
      if (move)
         rsp_ff <= step_result;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_field_kind  = rsp_ff.field_kind;
   assign rsp_entry_index = rsp_ff.entry_index;
   assign rsp_field_value = rsp_ff.field_value;
   assign rsp_value_valid = rsp_ff.value_valid;
   assign rsp_status      = rsp_ff.status;
   assign rsp_tx_done     = rsp_ff.tx_done;

endmodule

// File: rtl/core/tsp_checker.sv
// Port-level checks for the transaction stream parser, bound to the top level.
// Depends on tsp_pkg.
module tsp_checker
   import tsp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  rsp_field_kind,
   input logic [63:0] rsp_entry_index,
   input logic [63:0] rsp_field_value,
   input logic        rsp_value_valid,
   input logic [2:0]  rsp_status,
   input logic        rsp_tx_done
);

   // a stalled result must hold
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_field_value) &&
      $stable(rsp_status) && $stable(rsp_tx_done))
      else $error("result changed while stalled");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_value_valid |-> rsp_field_value == '0)
      else $error("field value without a completed field");

   // every final status ends the transaction, busy never does
   a_done_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_BUSY && rsp_status != ST_DISCARDING
      |-> rsp_tx_done)
      else $error("final status without tx_done");

   a_discard: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_field_kind == KIND_DISCARD |->
      rsp_status == ST_DISCARDING && !rsp_value_valid && rsp_entry_index == '0)
      else $error("discarded request with wrong tagging");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_BUSY |-> !rsp_tx_done)
      else $error("busy status with tx_done");

endmodule

bind transaction_stream_parser tsp_checker u_tsp_checker (.*);
